@@ rtl/l3d_pkg.sv @@
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared types and constants of the color 3D look-up table interpolator.
// ----------------------------------------------------------------------------
package l3d_pkg;

	// Fixed field widths of the ports.
	localparam int PIX_W       = 13;
	localparam int NODE_W      = 5;
	localparam int NUM_NODES_W = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_NODES   = 1'b0,
		CFG_INTERP_MODE = 1'b1
	} cfg_reg_t;

	// Interpolation modes.
	typedef enum logic {
		MODE_TRILINEAR = 1'b0,
		MODE_TETRA     = 1'b1
	} mode_t;

	// Register values after reset.
	localparam logic [NUM_NODES_W-1:0] NODES_RESET = 5'd17;
	localparam mode_t                  MODE_RESET  = MODE_TETRA;

	// Tetrahedron choice, named by the order of the fractions.
	typedef enum logic [2:0] {
		TET_BRG,
		TET_BGR,
		TET_GBR,
		TET_RBG,
		TET_RGB,
		TET_GRB
	} tet_t;

	// Per-pixel control that travels from the address stages to the datapath.
	// Bit 0 is red, bit 1 is green, bit 2 is blue.
	typedef struct packed {
		mode_t      mode;
		tet_t       sel;
		logic [2:0] lo_odd;
		logic [2:0] nz;
	} l3d_ctl_t;

endpackage

@@ rtl/l3d_bank.sv @@
// ----------------------------------------------------------------------------
// l3d_bank
// One bank of the node store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module l3d_bank #(
	parameter int DEPTH = 729,
	parameter int DW    = 48,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;

	// Read sees the contents written in earlier cycles only.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ rtl/l3d_chan.sv @@
// ----------------------------------------------------------------------------
// l3d_chan
// Interpolation datapath of one color channel, stages 5 to 11.
// ----------------------------------------------------------------------------
module l3d_chan #(
	parameter int FRAC_BITS   = 12,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  l3d_pkg::l3d_ctl_t             ctl,
	input  logic [FRAC_BITS-1:0]          frac [3],
	input  logic signed [ENTRY_WIDTH-1:0] bank [8],
	output logic signed [ENTRY_WIDTH-1:0] result
);

	localparam int W  = ENTRY_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = F + W + 2;
	localparam int AW = PW + 2;
	localparam int VW = W + 4;

	// Fraction times the difference of two nodes.
	function automatic logic signed [PW-1:0] fmul(input logic [F-1:0] f,
			input logic signed [W-1:0] hi, input logic signed [W-1:0] lo);
		logic signed [F:0] fs;
		logic signed [W:0] d;
		fs = {1'b0, f};
		d = (W+1)'(hi) - (W+1)'(lo);
		fmul = fs * d;
	endfunction

	// Base value plus a product scaled down, rounding toward minus infinity.
	function automatic logic signed [W-1:0] lerp_add(input logic signed [W-1:0] a,
			input logic signed [PW-1:0] p);
		logic signed [PW-1:0] s;
		s = (p >>> F) + PW'(a);
		lerp_add = W'(s);
	endfunction

	// Stage 5: corners from the banks; a zero fraction keeps the floor node.
	logic signed [W-1:0] c_s5 [8];
	l3d_pkg::l3d_ctl_t   ctl_s5;
	logic [F-1:0]        fr_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 8; k++) begin
				c_s5[k] <= bank[{ctl.lo_odd[0] ^ (k[2] & ctl.nz[0]),
						ctl.lo_odd[1] ^ (k[1] & ctl.nz[1]),
						ctl.lo_odd[2] ^ (k[0] & ctl.nz[2])}];
			end
			ctl_s5 <= ctl;
			for (int i = 0; i < 3; i++) begin
				fr_s5[i] <= frac[i];
			end
		end
	end

	// Stage 6: first products of both schemes.
	logic [F-1:0]        tf1, tf2, tf3;
	logic signed [W-1:0] tcx, tcy;

	always_comb begin
		tf1 = fr_s5[1];
		tf2 = fr_s5[0];
		tf3 = fr_s5[2];
		tcx = c_s5[3'b010];
		tcy = c_s5[3'b110];
		case (ctl_s5.sel)
			l3d_pkg::TET_BRG: begin
				tf1 = fr_s5[2]; tf2 = fr_s5[0]; tf3 = fr_s5[1];
				tcx = c_s5[3'b001]; tcy = c_s5[3'b101];
			end
			l3d_pkg::TET_BGR: begin
				tf1 = fr_s5[2]; tf2 = fr_s5[1]; tf3 = fr_s5[0];
				tcx = c_s5[3'b001]; tcy = c_s5[3'b011];
			end
			l3d_pkg::TET_GBR: begin
				tf1 = fr_s5[1]; tf2 = fr_s5[2]; tf3 = fr_s5[0];
				tcx = c_s5[3'b010]; tcy = c_s5[3'b011];
			end
			l3d_pkg::TET_RBG: begin
				tf1 = fr_s5[0]; tf2 = fr_s5[2]; tf3 = fr_s5[1];
				tcx = c_s5[3'b100]; tcy = c_s5[3'b101];
			end
			l3d_pkg::TET_RGB: begin
				tf1 = fr_s5[0]; tf2 = fr_s5[1]; tf3 = fr_s5[2];
				tcx = c_s5[3'b100]; tcy = c_s5[3'b110];
			end
			default: begin
				tf1 = fr_s5[1]; tf2 = fr_s5[0]; tf3 = fr_s5[2];
				tcx = c_s5[3'b010]; tcy = c_s5[3'b110];
			end
		endcase
	end

	logic signed [PW-1:0] p_s6 [4];
	logic signed [W-1:0]  a_s6 [4];
	logic signed [PW-1:0] t_s6 [3];
	logic signed [W-1:0]  c000_s6;
	logic [F-1:0]         fg_s6, fb_s6;
	l3d_pkg::mode_t       mode_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6[0] <= fmul(fr_s5[0], c_s5[3'b100], c_s5[3'b000]);
			p_s6[1] <= fmul(fr_s5[0], c_s5[3'b110], c_s5[3'b010]);
			p_s6[2] <= fmul(fr_s5[0], c_s5[3'b101], c_s5[3'b001]);
			p_s6[3] <= fmul(fr_s5[0], c_s5[3'b111], c_s5[3'b011]);
			a_s6[0] <= c_s5[3'b000];
			a_s6[1] <= c_s5[3'b010];
			a_s6[2] <= c_s5[3'b001];
			a_s6[3] <= c_s5[3'b011];
			t_s6[0] <= fmul(tf1, tcx, c_s5[3'b000]);
			t_s6[1] <= fmul(tf2, tcy, tcx);
			t_s6[2] <= fmul(tf3, c_s5[3'b111], tcy);
			c000_s6 <= c_s5[3'b000];
			fg_s6 <= fr_s5[1];
			fb_s6 <= fr_s5[2];
			mode_s6 <= ctl_s5.mode;
		end
	end

	// Stage 7: red lerps and the tetrahedral sum.
	logic signed [W-1:0]  x_s7 [4];
	logic signed [AW-1:0] acc_s7;
	logic signed [W-1:0]  c000_s7;
	logic [F-1:0]         fg_s7, fb_s7;
	l3d_pkg::mode_t       mode_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				x_s7[i] <= lerp_add(a_s6[i], p_s6[i]);
			end
			acc_s7 <= AW'(t_s6[0]) + AW'(t_s6[1]) + AW'(t_s6[2]);
			c000_s7 <= c000_s6;
			fg_s7 <= fg_s6;
			fb_s7 <= fb_s6;
			mode_s7 <= mode_s6;
		end
	end

	// Stage 8: green products and the tetrahedral value.
	logic signed [PW-1:0] q_s8 [2];
	logic signed [W-1:0]  x0_s8, x2_s8;
	logic signed [VW-1:0] v_s8;
	logic [F-1:0]         fb_s8;
	l3d_pkg::mode_t       mode_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s8[0] <= fmul(fg_s7, x_s7[1], x_s7[0]);
			q_s8[1] <= fmul(fg_s7, x_s7[3], x_s7[2]);
			x0_s8 <= x_s7[0];
			x2_s8 <= x_s7[2];
			v_s8 <= VW'(c000_s7) + VW'(acc_s7 >>> F);
			fb_s8 <= fb_s7;
			mode_s8 <= mode_s7;
		end
	end

	// Stage 9: green lerps.
	logic signed [W-1:0]  y0_s9, y1_s9;
	logic signed [VW-1:0] v_s9;
	logic [F-1:0]         fb_s9;
	l3d_pkg::mode_t       mode_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			y0_s9 <= lerp_add(x0_s8, q_s8[0]);
			y1_s9 <= lerp_add(x2_s8, q_s8[1]);
			v_s9 <= v_s8;
			fb_s9 <= fb_s8;
			mode_s9 <= mode_s8;
		end
	end

	// Stage 10: blue product.
	logic signed [PW-1:0] r_s10;
	logic signed [W-1:0]  y0_s10;
	logic signed [VW-1:0] v_s10;
	l3d_pkg::mode_t       mode_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s10 <= fmul(fb_s9, y1_s9, y0_s9);
			y0_s10 <= y0_s9;
			v_s10 <= v_s9;
			mode_s10 <= mode_s9;
		end
	end

	// Stage 11: final blue lerp, mode select and saturation.
	localparam logic signed [VW-1:0] SAT_HI = VW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

	logic signed [VW-1:0] fin;
	logic signed [W-1:0]  res_s11;

	always_comb begin
		if (mode_s10 == l3d_pkg::MODE_TRILINEAR) begin
			fin = VW'(lerp_add(y0_s10, r_s10));
		end else begin
			fin = v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin > SAT_HI) begin
				res_s11 <= SAT_HI[W-1:0];
			end else if (fin < SAT_LO) begin
				res_s11 <= SAT_LO[W-1:0];
			end else begin
				res_s11 <= fin[W-1:0];
			end
		end
	end

	assign result = res_s11;

endmodule

@@ rtl/lut3d_color_interpolator.sv @@
// ----------------------------------------------------------------------------
// lut3d_color_interpolator
// Color 3D look-up table with trilinear and tetrahedral interpolation.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output is not stalled,
// load or pixel, and returns the result of each pixel; loads give no result. The
// node store is split into eight banks by the parity of the three node
// indexes, so the eight corners of a cell come from eight single read ports
// in the same cycle. A stall on the output holds the whole pipeline, and the
// input stall follows it in the same cycle. Loads and pixels go through the
// store in order, so a pixel sees every load accepted before it. Reading a
// node that was never loaded returns an undefined value.
// ----------------------------------------------------------------------------
module lut3d_color_interpolator #(
	parameter int MAX_NODES   = 17,
	parameter int FRAC_BITS   = 12,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [l3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [l3d_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [l3d_pkg::NODE_W-1:0]          node_r,
	input  logic [l3d_pkg::NODE_W-1:0]          node_g,
	input  logic [l3d_pkg::NODE_W-1:0]          node_b,
	input  logic signed [ENTRY_WIDTH-1:0]       entry_red,
	input  logic signed [ENTRY_WIDTH-1:0]       entry_green,
	input  logic signed [ENTRY_WIDTH-1:0]       entry_blue,
	input  logic [l3d_pkg::PIX_W-1:0]           pix_red,
	input  logic [l3d_pkg::PIX_W-1:0]           pix_green,
	input  logic [l3d_pkg::PIX_W-1:0]           pix_blue,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ENTRY_WIDTH-1:0]       out_red,
	output logic signed [ENTRY_WIDTH-1:0]       out_green,
	output logic signed [ENTRY_WIDTH-1:0]       out_blue
);

	localparam int W     = ENTRY_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int PCW   = F + 1;
	localparam int PXW   = (l3d_pkg::PIX_W > PCW) ? l3d_pkg::PIX_W : PCW;
	localparam int TW    = PCW + CW;
	localparam int HB    = MAX_NODES / 2 + 1;
	localparam int HW    = $clog2(HB);
	localparam int DEPTH = HB * HB * HB;
	localparam int BAW   = $clog2(DEPTH);
	localparam int DW    = 3 * W;
	localparam logic [PCW-1:0] ONE = {1'b1, {F{1'b0}}};

	// Bank address of a node from its halved indexes.
	function automatic logic [BAW-1:0] bank_addr(input logic [HW-1:0] hr,
			input logic [HW-1:0] hg, input logic [HW-1:0] hb);
		bank_addr = BAW'((int'(hr) * HB + int'(hg)) * HB + int'(hb));
	endfunction

	// Configuration registers.
	logic [l3d_pkg::NUM_NODES_W-1:0] nodes_q;
	l3d_pkg::mode_t                  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= l3d_pkg::NODES_RESET;
			mode_q <= l3d_pkg::MODE_RESET;
		end else if (cfg_we) begin
			case (l3d_pkg::cfg_reg_t'(cfg_index))
				l3d_pkg::CFG_NUM_NODES:   nodes_q <= cfg_data[l3d_pkg::NUM_NODES_W-1:0];
				l3d_pkg::CFG_INTERP_MODE: mode_q <= l3d_pkg::mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// Global pipeline enable: everything holds while a result waits.
	logic en;
	logic vld_s11;

	assign en = !(vld_s11 && out_stall);
	assign in_stall = !en;

	// Stage 1: clamp the node count and the pixel components.
	logic [CW-1:0]  nm1_c;
	logic [PCW-1:0] pc_c [3];
	logic [PXW-1:0] px_c [3];

	always_comb begin
		if (nodes_q < l3d_pkg::NUM_NODES_W'(2)) begin
			nm1_c = CW'(1);
		end else if (int'(nodes_q) > MAX_NODES) begin
			nm1_c = CW'(MAX_NODES - 1);
		end else begin
			nm1_c = CW'(nodes_q) - CW'(1);
		end
		px_c[0] = PXW'(pix_red);
		px_c[1] = PXW'(pix_green);
		px_c[2] = PXW'(pix_blue);
		for (int i = 0; i < 3; i++) begin
			if (px_c[i] > PXW'(ONE)) begin
				pc_c[i] = ONE;
			end else begin
				pc_c[i] = PCW'(px_c[i]);
			end
		end
	end

	logic                       vld_s1;
	logic                       pix_s1;
	logic [l3d_pkg::NODE_W-1:0] node_s1 [3];
	logic [DW-1:0]              ent_s1;
	logic [PCW-1:0]             pc_s1 [3];
	logic [CW-1:0]              nm1_s1;
	l3d_pkg::mode_t             mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= func;
			node_s1[0] <= node_r;
			node_s1[1] <= node_g;
			node_s1[2] <= node_b;
			ent_s1 <= {entry_blue, entry_green, entry_red};
			for (int i = 0; i < 3; i++) begin
				pc_s1[i] <= pc_c[i];
			end
			nm1_s1 <= nm1_c;
			mode_s1 <= mode_q;
		end
	end

	// Stage 2: scale into floor index and fraction; decode the load target.
	logic [TW-1:0]  t_c [3];
	logic [HW-1:0]  wh_c [3];
	logic           wok_c;

	always_comb begin
		wok_c = !pix_s1;
		for (int i = 0; i < 3; i++) begin
			t_c[i] = TW'(pc_s1[i]) * TW'(nm1_s1);
			wh_c[i] = HW'(node_s1[i] >> 1);
			if (int'(node_s1[i]) >= MAX_NODES) begin
				wok_c = 1'b0;
			end
		end
	end

	logic           vld_s2;
	logic           pix_s2;
	logic [CW-1:0]  lo_s2 [3];
	logic [F-1:0]   fr_s2 [3];
	logic           we_s2;
	logic [2:0]     wbank_s2;
	logic [BAW-1:0] waddr_s2;
	logic [DW-1:0]  ent_s2;
	l3d_pkg::mode_t mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s2 <= pix_s1;
			for (int i = 0; i < 3; i++) begin
				lo_s2[i] <= CW'(t_c[i] >> F);
				fr_s2[i] <= t_c[i][F-1:0];
			end
			we_s2 <= wok_c;
			wbank_s2 <= {node_s1[0][0], node_s1[1][0], node_s1[2][0]};
			waddr_s2 <= bank_addr(wh_c[0], wh_c[1], wh_c[2]);
			ent_s2 <= ent_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: per-bank read addresses and the tetrahedron choice.
	logic [CW-1:0]     coord_c;
	logic [HW-1:0]     rh_c [3];
	logic [BAW-1:0]    raddr_c [8];
	logic [2:0]        kk;
	l3d_pkg::tet_t     sel_c;

	always_comb begin
		coord_c = '0;
		kk = '0;
		for (int i = 0; i < 3; i++) begin
			rh_c[i] = '0;
		end
		for (int k = 0; k < 8; k++) begin
			kk = 3'(k);
			for (int i = 0; i < 3; i++) begin
				if (lo_s2[i][0] == kk[2-i]) begin
					coord_c = lo_s2[i];
				end else begin
					coord_c = lo_s2[i] + CW'(1);
				end
				rh_c[i] = HW'(coord_c >> 1);
			end
			raddr_c[k] = bank_addr(rh_c[0], rh_c[1], rh_c[2]);
		end
	end

	always_comb begin
		if (fr_s2[2] > fr_s2[0] && fr_s2[0] > fr_s2[1]) begin
			sel_c = l3d_pkg::TET_BRG;
		end else if (fr_s2[2] > fr_s2[1] && fr_s2[1] > fr_s2[0]) begin
			sel_c = l3d_pkg::TET_BGR;
		end else if (fr_s2[1] > fr_s2[2] && fr_s2[2] > fr_s2[0]) begin
			sel_c = l3d_pkg::TET_GBR;
		end else if (fr_s2[0] > fr_s2[2] && fr_s2[2] > fr_s2[1]) begin
			sel_c = l3d_pkg::TET_RBG;
		end else if (fr_s2[0] > fr_s2[1] && fr_s2[1] > fr_s2[2]) begin
			sel_c = l3d_pkg::TET_RGB;
		end else begin
			sel_c = l3d_pkg::TET_GRB;
		end
	end

	logic              vld_s3;
	logic [BAW-1:0]    raddr_s3 [8];
	logic              we_s3;
	logic [2:0]        wbank_s3;
	logic [BAW-1:0]    waddr_s3;
	logic [DW-1:0]     wdata_s3;
	l3d_pkg::l3d_ctl_t ctl_s3;
	logic [F-1:0]      fr_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			we_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2 && pix_s2;
			we_s3 <= vld_s2 && we_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 8; k++) begin
				raddr_s3[k] <= raddr_c[k];
			end
			wbank_s3 <= wbank_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= ent_s2;
			ctl_s3.mode <= mode_s2;
			ctl_s3.sel <= sel_c;
			for (int i = 0; i < 3; i++) begin
				ctl_s3.lo_odd[i] <= lo_s2[i][0];
				ctl_s3.nz[i] <= |fr_s2[i];
				fr_s3[i] <= fr_s2[i];
			end
		end
	end

	// Stage 4: node store, eight banks by index parity.
	logic [DW-1:0] rd_s4 [8];

	for (genvar k = 0; k < 8; k++) begin : g_bank
		l3d_bank #(
			.DEPTH(DEPTH),
			.DW   (DW)
		) u_bank (
			.clk  (clk),
			.en   (en),
			.we   (we_s3 && (wbank_s3 == 3'(k))),
			.waddr(waddr_s3),
			.wdata(wdata_s3),
			.raddr(raddr_s3[k]),
			.rdata(rd_s4[k])
		);
	end

	logic              vld_s4;
	l3d_pkg::l3d_ctl_t ctl_s4;
	logic [F-1:0]      fr_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= ctl_s3;
			for (int i = 0; i < 3; i++) begin
				fr_s4[i] <= fr_s3[i];
			end
		end
	end

	// Stages 5 to 11: one interpolation datapath per channel.
	logic signed [W-1:0] res [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic signed [W-1:0] corner [8];

		for (genvar k = 0; k < 8; k++) begin : g_corner
			assign corner[k] = rd_s4[k][ch*W +: W];
		end

		l3d_chan #(
			.FRAC_BITS  (FRAC_BITS),
			.ENTRY_WIDTH(ENTRY_WIDTH)
		) u_chan (
			.clk   (clk),
			.en    (en),
			.ctl   (ctl_s4),
			.frac  (fr_s4),
			.bank  (corner),
			.result(res[ch])
		);
	end

	// Valid bits that follow the datapath stages.
	logic vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	assign out_valid = vld_s11;
	assign out_red   = res[0];
	assign out_green = res[1];
	assign out_blue  = res[2];

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color 3D look-up table interpolator. A lattice
// of node coordinates is loaded first, and then directed and random load and
// pixel transactions run through several table sizes, both interpolation
// modes, and several idle and stall patterns. Pixels are chosen so that every
// corner they touch lies on the loaded lattice. A model inside the bench
// predicts every pixel result, and the monitor compares each output field in
// order.
// ----------------------------------------------------------------------------
module tb;

	localparam int  MAXN       = 17;
	localparam int  CUBE       = MAXN * MAXN * MAXN;
	localparam int  ONE        = 4096;
	localparam int  DRAIN      = 24;
	localparam int  CYCLE_CAP  = 600000;
	localparam int  PHASE_TXNS = 40;
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Node coordinates that are loaded on every axis.
	localparam int LOAD_N = 9;
	localparam int LOAD_COORDS [LOAD_N] = '{0, 1, 2, 3, 4, 8, 9, 15, 16};

	// Table size, mode and traffic pattern of each random phase.
	localparam int   PHASE_NODES [8] = '{17, 2, 17, 5, 0, 31, 9, 16};
	localparam logic PHASE_MODE [8] = '{l3d_pkg::MODE_TETRA, l3d_pkg::MODE_TRILINEAR,
		l3d_pkg::MODE_TRILINEAR, l3d_pkg::MODE_TETRA, l3d_pkg::MODE_TETRA,
		l3d_pkg::MODE_TRILINEAR, l3d_pkg::MODE_TRILINEAR, l3d_pkg::MODE_TETRA};
	localparam int   IDLE_SET [4] = '{0, 84, 0, 32};
	localparam int   STALL_SET [4] = '{0, 0, 84, 32};

	typedef struct {
		logic        fn;
		logic [4:0]  nr, ng, nb;
		logic [15:0] er, eg, eb;
		logic [12:0] pr, pg, pb;
	} lut_txn_t;

	typedef struct {
		logic [15:0] red, green, blue;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [l3d_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [l3d_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [4:0] node_r = '0, node_g = '0, node_b = '0;
	logic signed [15:0] entry_red = '0, entry_green = '0, entry_blue = '0;
	logic [12:0] pix_red = '0, pix_green = '0, pix_blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_red, out_green, out_blue;

	lut3d_color_interpolator u_dut (.*);

	// Bench state: pending transactions, expected pixels and the node cube.
	lut_txn_t pending_txns[$];
	rgb_t     expected_pixels[$];
	int       cube[CUBE][3];
	int       nodes_cfg = 17;
	logic     mode_cfg = l3d_pkg::MODE_TETRA;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	bit       send_hold = 1'b0;
	int       errors = 0;
	int       cycles = 0;

	// Clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Append a transaction to the send queue.
	function automatic void queue_txn(lut_txn_t t);
		pending_txns.insert(pending_txns.size(), t);
	endfunction

	// Append a predicted pixel to the expected queue.
	function automatic void queue_expected(rgb_t e);
		expected_pixels.insert(expected_pixels.size(), e);
	endfunction

	// Split one component into floor index, ceiling index and fraction.
	function automatic void split_axis(input int p, input int n, output int lo,
			output int hi, output longint fr);
		int t;
		if (p > ONE)
			p = ONE;
		t = p * (n - 1);
		lo = t >> 12;
		fr = t & (ONE - 1);
		hi = lo + ((fr != 0) ? 1 : 0);
	endfunction

	function automatic longint lerp12(longint a, longint b, longint f);
		return a + ((f * (b - a)) >>> 12);
	endfunction

	// Interpolate one pixel over the current cube and configuration.
	function automatic rgb_t interpolate_pixel(int pr, int pg, int pb);
		int n, r0, r1, g0, g1, b0, b1;
		longint fr, fg, fb, v, acc;
		longint c000, c100, c010, c110, c001, c101, c011, c111;
		logic [15:0] res[3];
		rgb_t o;
		n = nodes_cfg < 2 ? 2 : (nodes_cfg > MAXN ? MAXN : nodes_cfg);
		split_axis(pr, n, r0, r1, fr);
		split_axis(pg, n, g0, g1, fg);
		split_axis(pb, n, b0, b1, fb);
		for (int ch = 0; ch < 3; ch++) begin
			c000 = cube[(r0 * MAXN + g0) * MAXN + b0][ch];
			c100 = cube[(r1 * MAXN + g0) * MAXN + b0][ch];
			c010 = cube[(r0 * MAXN + g1) * MAXN + b0][ch];
			c110 = cube[(r1 * MAXN + g1) * MAXN + b0][ch];
			c001 = cube[(r0 * MAXN + g0) * MAXN + b1][ch];
			c101 = cube[(r1 * MAXN + g0) * MAXN + b1][ch];
			c011 = cube[(r0 * MAXN + g1) * MAXN + b1][ch];
			c111 = cube[(r1 * MAXN + g1) * MAXN + b1][ch];
			if (mode_cfg == l3d_pkg::MODE_TRILINEAR) begin
				v = lerp12(lerp12(lerp12(c000, c100, fr), lerp12(c010, c110, fr), fg),
					lerp12(lerp12(c001, c101, fr), lerp12(c011, c111, fr), fg), fb);
			end else begin
				if (fb > fr && fr > fg)
					acc = fb * (c001 - c000) + fr * (c101 - c001) + fg * (c111 - c101);
				else if (fb > fg && fg > fr)
					acc = fb * (c001 - c000) + fg * (c011 - c001) + fr * (c111 - c011);
				else if (fg > fb && fb > fr)
					acc = fg * (c010 - c000) + fb * (c011 - c010) + fr * (c111 - c011);
				else if (fr > fb && fb > fg)
					acc = fr * (c100 - c000) + fb * (c101 - c100) + fg * (c111 - c101);
				else if (fr > fg && fg > fb)
					acc = fr * (c100 - c000) + fg * (c110 - c100) + fb * (c111 - c110);
				else
					acc = fg * (c010 - c000) + fr * (c110 - c010) + fb * (c111 - c110);
				v = c000 + (acc >>> 12);
			end
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			res[ch] = v[15:0];
		end
		o.red = res[0];
		o.green = res[1];
		o.blue = res[2];
		return o;
	endfunction

	// Driver: record each accepted transaction, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				if (func == FUNC_LOAD) begin
					if (node_r < MAXN && node_g < MAXN && node_b < MAXN) begin
						cube[(node_r * MAXN + node_g) * MAXN + node_b][0] = entry_red;
						cube[(node_r * MAXN + node_g) * MAXN + node_b][1] = entry_green;
						cube[(node_r * MAXN + node_g) * MAXN + node_b][2] = entry_blue;
					end
				end else begin
					queue_expected(interpolate_pixel(pix_red, pix_green, pix_blue));
				end
			end
			if (pending_txns.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
				lut_txn_t t;
				t = pending_txns.pop_front();
				in_valid <= 1'b1;
				func <= t.fn;
				node_r <= t.nr;
				node_g <= t.ng;
				node_b <= t.nb;
				entry_red <= t.er;
				entry_green <= t.eg;
				entry_blue <= t.eb;
				pix_red <= t.pr;
				pix_green <= t.pg;
				pix_blue <= t.pb;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expected pixel.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected result", out_red, 0);
			end else begin
				rgb_t e;
				e = expected_pixels.pop_front();
				if (out_red !== e.red)
					report_mismatch("out_red", out_red, $signed(e.red));
				if (out_green !== e.green)
					report_mismatch("out_green", out_green, $signed(e.green));
				if (out_blue !== e.blue)
					report_mismatch("out_blue", out_blue, $signed(e.blue));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Timeout.
	always @(posedge clk) begin
		if (cycles >= CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic lut_txn_t load_txn(int r, int g, int b);
		lut_txn_t t;
		t.fn = FUNC_LOAD;
		t.nr = 5'(r);
		t.ng = 5'(g);
		t.nb = 5'(b);
		t.er = 16'($urandom);
		t.eg = 16'($urandom);
		t.eb = 16'($urandom);
		t.pr = 13'($urandom);
		t.pg = 13'($urandom);
		t.pb = 13'($urandom);
		return t;
	endfunction

	function automatic lut_txn_t pixel_txn(int r, int g, int b);
		lut_txn_t t;
		t = load_txn(0, 0, 0);
		t.fn = FUNC_PIXEL;
		t.nr = 5'($urandom);
		t.ng = 5'($urandom);
		t.nb = 5'($urandom);
		t.pr = 13'(r);
		t.pg = 13'(g);
		t.pb = 13'(b);
		return t;
	endfunction

	// True when a node coordinate is one that the lattice loads.
	function automatic bit on_lattice(int v);
		for (int i = 0; i < LOAD_N; i++) begin
			if (LOAD_COORDS[i] == v)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Random lattice coordinate.
	function automatic int rand_coord();
		return LOAD_COORDS[$urandom_range(LOAD_N - 1)];
	endfunction

	// Random pixel component, weighted toward the grid edges and saturation.
	function automatic int rand_comp();
		case ($urandom_range(7))
			0: return 0;
			1: return ONE;
			2: return $urandom_range(8191, ONE + 1);
			default: return $urandom_range(ONE);
		endcase
	endfunction

	// Random component whose floor and ceiling nodes are both loaded.
	function automatic int pick_comp();
		int p, n, lo, hi;
		longint fr;
		n = nodes_cfg < 2 ? 2 : (nodes_cfg > MAXN ? MAXN : nodes_cfg);
		do begin
			p = rand_comp();
			split_axis(p, n, lo, hi, fr);
		end while (!on_lattice(lo) || !on_lattice(hi));
		return p;
	endfunction

	task automatic wait_quiet();
		while (pending_txns.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_config(int n, logic m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= l3d_pkg::CFG_NUM_NODES;
		cfg_data <= l3d_pkg::CFG_DATA_W'(n);
		@(posedge clk);
		cfg_index <= l3d_pkg::CFG_INTERP_MODE;
		cfg_data <= l3d_pkg::CFG_DATA_W'(m);
		@(posedge clk);
		cfg_we <= 1'b0;
		nodes_cfg = n;
		mode_cfg = m;
	endtask

	task automatic queue_random(int count);
		int c0, c1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				if ($urandom_range(7) == 0)
					queue_txn(load_txn($urandom_range(31), $urandom_range(31),
						$urandom_range(31)));
				else
					queue_txn(load_txn(rand_coord(), rand_coord(), rand_coord()));
			end else begin
				c0 = pick_comp();
				c1 = pick_comp();
				// Equal fractions now and then, to reach the tie cases.
				case ($urandom_range(5))
					0: queue_txn(pixel_txn(c0, c0, c1));
					1: queue_txn(pixel_txn(c1, c0, c0));
					2: queue_txn(pixel_txn(c0, c1, c0));
					default: queue_txn(pixel_txn(c0, c1, pick_comp()));
				endcase
			end
		end
	endtask

	// Stimulus: fill the lattice, directed cases, then random phases.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < LOAD_N; r++)
			for (int g = 0; g < LOAD_N; g++)
				for (int b = 0; b < LOAD_N; b++)
					queue_txn(load_txn(LOAD_COORDS[r], LOAD_COORDS[g], LOAD_COORDS[b]));
		// Directed: extremes, each tetrahedron, ties, saturation, ignored loads.
		queue_txn(pixel_txn(0, 0, 0));
		queue_txn(pixel_txn(ONE, ONE, ONE));
		queue_txn(pixel_txn(8191, 8191, 8191));
		queue_txn(pixel_txn(4097, 0, 6000));
		queue_txn(pixel_txn(100, 50, 200));
		queue_txn(pixel_txn(50, 100, 200));
		queue_txn(pixel_txn(50, 200, 100));
		queue_txn(pixel_txn(200, 50, 100));
		queue_txn(pixel_txn(200, 100, 50));
		queue_txn(pixel_txn(100, 200, 50));
		queue_txn(pixel_txn(123, 123, 123));
		queue_txn(pixel_txn(200, 200, 10));
		queue_txn(pixel_txn(10, 200, 200));
		queue_txn(load_txn(17, 0, 0));
		queue_txn(load_txn(0, 31, 0));
		queue_txn(load_txn(0, 0, 20));
		queue_txn(load_txn(16, 16, 16));
		queue_txn(pixel_txn(ONE, ONE, ONE));
		queue_txn(pixel_txn(4095, 1, 2048));
		wait_quiet();
		for (int p = 0; p < 8; p++) begin
			write_config(PHASE_NODES[p], PHASE_MODE[p]);
			send_idle_pct = IDLE_SET[p % 4];
			stall_pct = STALL_SET[p % 4];
			queue_random(PHASE_TXNS);
			if (p == 1) begin
				// Hold the sender until every outstanding pixel has come back.
				while (pending_txns.size() > PHASE_TXNS / 2)
					@(posedge clk);
				send_hold = 1'b1;
				while (in_valid || expected_pixels.size() != 0)
					@(posedge clk);
				send_hold = 1'b0;
			end
			wait_quiet();
		end
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
